@@ hw/rtl/lfvds_pkg.sv @@
// ----------------------------------------------------------------------------
// lfvds_pkg
// shared types and constants of the voltage display fade sequencer
// ----------------------------------------------------------------------------
package lfvds_pkg;

  localparam int unsigned BrightW = 8;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned HoldW   = 16;
  localparam int unsigned ActW    = 3;

  // iterative divider: 16-bit dividend, 8-bit divisor
  localparam int unsigned DivNumW = 16;
  localparam int unsigned DivDenW = 8;
  localparam int unsigned DivCntW = $clog2(DivNumW);

  localparam logic [BrightW-1:0] FadeOutStep = 8'd8;
  localparam logic [CfgW-1:0]    ThreshOff   = 8'd255;

  // event codes
  localparam logic [ActW-1:0] ACT_ENTER  = 3'd0;
  localparam logic [ActW-1:0] ACT_LEAVE  = 3'd1;
  localparam logic [ActW-1:0] ACT_TICK   = 3'd2;
  localparam logic [ActW-1:0] ACT_BUTTON = 3'd3;
  localparam logic [ActW-1:0] ACT_SLEEP  = 3'd4;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_HOLD_SECONDS   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LAST_LEVEL     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOW_THRESHOLD  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_HIGH_THRESHOLD = 2'd3;

  // divider operand select
  localparam logic DIV_SEL_TARGET = 1'b0;
  localparam logic DIV_SEL_STEP   = 1'b1;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic            sensor_on_other_channel;
    logic            main_fade_busy;
  } in_t;

  typedef struct packed {
    logic [BrightW-1:0] brightness;
    logic               frame_drawn;
    logic               leds_off;
    logic               exit_request;
  } out_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_sel;
    logic tgt_load;
    logic tgt_from_div;
    logic step_load;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic fade_tick;
    logic tgt_div;
    logic tgt_gt_b;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

@@ hw/rtl/lfvds_if.sv @@
// ----------------------------------------------------------------------------
// lfvds channel interfaces
// valid/ready channels for events in and frame results out
// ----------------------------------------------------------------------------
interface lfvds_in_if;
  import lfvds_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lfvds_out_if;
  import lfvds_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/led_fade_voltage_display_sequencer.sv @@
// ----------------------------------------------------------------------------
// led_fade_voltage_display_sequencer
// brightness sequencer for the voltage display shown after switching off
// ----------------------------------------------------------------------------
// usage:
//   in_i carries one event per transaction (enter, leave, tick, button,
//   sleep tick); out_o returns exactly one result transaction per event
//   with the frame brightness and the leds_off / exit_request flags.
//   the config port (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes hold time,
//   last ramp level and the two thresholds; write it only while idle.
// sequencing:
//   one event at a time. a non fade-in event passes from accept through
//   decode to the commit state; a fade-in tick runs the shared serial
//   divider up to twice (target scaling, then step size) between decode
//   and commit. a new event is accepted only after the previous one has
//   committed.
// reset:
//   clears phase, brightness and hold count, loads register defaults;
//   no result is pending after reset.
// stall:
//   the result sits in an output register; the next event is accepted and
//   worked on meanwhile, and only its commit waits for the register.
// ----------------------------------------------------------------------------
module led_fade_voltage_display_sequencer #(
  parameter int unsigned RAMP_TOP         = 150,
  parameter int unsigned FADE_IN_DIVISOR  = 5,
  parameter int unsigned WAIT_TICKS       = 16,
  parameter int unsigned TICKS_PER_SECOND = 62
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lfvds_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lfvds_pkg::CfgW-1:0]    cfg_wdata_i,
  lfvds_in_if.sink                      in_i,
  lfvds_out_if.source                   out_o
);
  import lfvds_pkg::*;

  // command and status between controller and datapath
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  lfvds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lfvds_dp #(
    .RAMP_TOP         (RAMP_TOP),
    .FADE_IN_DIVISOR  (FADE_IN_DIVISOR),
    .WAIT_TICKS       (WAIT_TICKS),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

  assign in_i.ready = in_ready;

  // a commit never overwrites a result that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_o.valid || out_o.ready))
    else $error("commit while result register is held");

  // one event in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> !in_ready)
    else $error("second event accepted while one is in flight");

  // a committed event shows up as a valid result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_o.valid)
    else $error("committed result not presented");

  // the divider is never restarted while the controller waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> !cmd.div_start)
    else $error("divider started twice in a row");

endmodule

@@ hw/rtl/lfvds_div.sv @@
// ----------------------------------------------------------------------------
// lfvds_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lfvds_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lfvds_pkg::DivNumW-1:0] num_i,
  input  logic [lfvds_pkg::DivDenW-1:0] den_i,
  output logic [lfvds_pkg::DivNumW-1:0] quo_o,
  output logic                          done_o
);
  import lfvds_pkg::*;

  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivDenW-1:0] den_q;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivDenW:0]   shifted;
  logic               fits;

  always_comb begin
    shifted = {rem_q, quo_q[DivNumW-1]};
    fits    = shifted >= {1'b0, den_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DivNumW-2:0], fits};
      rem_d = fits ? DivDenW'(shifted - {1'b0, den_q}) : shifted[DivDenW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivNumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

@@ hw/rtl/lfvds_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfvds_ctrl
// sequencing of one event: decode, target divide, step divide, commit
// ----------------------------------------------------------------------------
module lfvds_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lfvds_pkg::sts_t     sts_i,
  output lfvds_pkg::cmd_t     cmd_o
);
  import lfvds_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_TGT  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_STEP = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.fade_tick && sts_i.tgt_div) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_SEL_TARGET;
          state_d         = S_TGT;
        end else if (sts_i.fade_tick) begin
          cmd_o.tgt_load = 1'b1;
          state_d        = S_CMP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_TGT: begin
        if (sts_i.div_done) begin
          cmd_o.tgt_load     = 1'b1;
          cmd_o.tgt_from_div = 1'b1;
          state_d            = S_CMP;
        end
      end
      S_CMP: begin
        if (sts_i.tgt_gt_b) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_SEL_STEP;
          state_d         = S_STEP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_STEP: begin
        if (sts_i.div_done) begin
          cmd_o.step_load = 1'b1;
          state_d         = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

@@ hw/rtl/lfvds_dp.sv @@
// ----------------------------------------------------------------------------
// lfvds_dp
// config registers, sequencer state, target and step math, result register
// ----------------------------------------------------------------------------
module lfvds_dp #(
  parameter int unsigned RAMP_TOP         = 150,
  parameter int unsigned FADE_IN_DIVISOR  = 5,
  parameter int unsigned WAIT_TICKS       = 16,
  parameter int unsigned TICKS_PER_SECOND = 62
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lfvds_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lfvds_pkg::CfgW-1:0]    cfg_wdata_i,
  input  lfvds_pkg::in_t                in_data_i,
  input  lfvds_pkg::cmd_t               cmd_i,
  output lfvds_pkg::sts_t               sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lfvds_pkg::out_t               out_data_o
);
  import lfvds_pkg::*;

  localparam int unsigned PhaseW = $clog2(WAIT_TICKS + 4);
  localparam logic [PhaseW-1:0] PhFadeIn  = PhaseW'(WAIT_TICKS);
  localparam logic [PhaseW-1:0] PhHold    = PhaseW'(WAIT_TICKS + 1);
  localparam logic [PhaseW-1:0] PhFadeOut = PhaseW'(WAIT_TICKS + 2);

  // config
  logic [CfgW-1:0] hold_seconds_q, last_level_q, low_threshold_q, high_threshold_q;

  // sequencer state
  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [BrightW-1:0] bright_q, bright_d;
  logic [HoldW-1:0]   hold_q, hold_d;

  // per-event working registers
  in_t                ev_q;
  logic [BrightW-1:0] target_q;
  logic [BrightW-1:0] step_q;
  out_t               out_q, out_d;
  logic               out_valid_q;

  // target math
  logic [CfgW-1:0]    hi, lo;
  logic [BrightW-1:0] tgt_direct;
  logic               tgt_div;
  logic [DivNumW-1:0] div_num;
  logic [DivDenW-1:0] div_den;
  logic [DivNumW-1:0] div_quo;
  logic               div_done;
  logic               is_done;
  logic [BrightW-1:0] step_eff;
  logic [HoldW-1:0]   hold_dec;

  always_comb begin
    hi = (high_threshold_q == ThreshOff) ? ThreshOff : high_threshold_q + 8'd1;
    lo = (low_threshold_q < hi) ? low_threshold_q : hi - 8'd1;
    tgt_div = 1'b0;
    if (last_level_q == '0 || last_level_q < lo) begin
      tgt_direct = '0;
    end else if (last_level_q < hi) begin
      tgt_direct = '0;
      tgt_div    = 1'b1;
    end else begin
      tgt_direct = BrightW'(RAMP_TOP);
    end
  end

  // divider operands; the product is registered at divider start
  always_comb begin
    if (cmd_i.div_sel == DIV_SEL_STEP) begin
      div_num = DivNumW'(target_q - bright_q);
      div_den = DivDenW'(FADE_IN_DIVISOR);
    end else begin
      div_num = DivNumW'(RAMP_TOP) * DivNumW'(last_level_q - lo);
      div_den = hi - lo;
    end
  end

  lfvds_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quo_o   (div_quo),
    .done_o  (div_done)
  );

  assign is_done = phase_q > PhFadeOut;

  always_comb begin
    sts_o.fade_tick = (ev_q.action == ACT_TICK) && !is_done && !ev_q.main_fade_busy &&
                      !ev_q.sensor_on_other_channel && (phase_q == PhFadeIn);
    sts_o.tgt_div   = tgt_div;
    sts_o.tgt_gt_b  = target_q > bright_q;
    sts_o.div_done  = div_done;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // state update and result of the captured event
  always_comb begin
    step_eff = (step_q == '0) ? BrightW'(1) : step_q;
    hold_dec = (hold_q != '0) ? hold_q - 1'b1 : hold_q;
    phase_d  = phase_q;
    bright_d = bright_q;
    hold_d   = hold_q;
    out_d    = '0;
    if (ev_q.action == ACT_ENTER) begin
      phase_d  = '0;
      bright_d = '0;
      hold_d   = HoldW'(hold_seconds_q) * HoldW'(TICKS_PER_SECOND);
    end else if (ev_q.action == ACT_LEAVE) begin
      out_d.leds_off = 1'b1;
    end else if (ev_q.action == ACT_BUTTON || ev_q.action == ACT_SLEEP || is_done) begin
      out_d.exit_request = 1'b1;
    end else if (!ev_q.main_fade_busy && ev_q.action == ACT_TICK &&
                 !ev_q.sensor_on_other_channel) begin
      if (phase_q < PhFadeIn) begin
        phase_d = phase_q + 1'b1;
      end else if (phase_q == PhFadeIn) begin
        if (target_q > bright_q) begin
          bright_d = bright_q + step_eff;
        end else begin
          phase_d = phase_q + 1'b1;
        end
      end else if (phase_q == PhHold) begin
        hold_d = hold_dec;
        if (hold_dec == '0) begin
          phase_d = phase_q + 1'b1;
        end
      end else begin
        if (bright_q > FadeOutStep) begin
          bright_d = bright_q - FadeOutStep;
        end else begin
          bright_d = '0;
          phase_d  = phase_q + 1'b1;
        end
      end
      out_d.brightness  = bright_d;
      out_d.frame_drawn = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_seconds_q   <= 8'd4;
      last_level_q     <= '0;
      low_threshold_q  <= '0;
      high_threshold_q <= ThreshOff;
      phase_q          <= '0;
      bright_q         <= '0;
      hold_q           <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_HOLD_SECONDS:   hold_seconds_q   <= cfg_wdata_i;
          CFG_LAST_LEVEL:     last_level_q     <= cfg_wdata_i;
          CFG_LOW_THRESHOLD:  low_threshold_q  <= cfg_wdata_i;
          CFG_HIGH_THRESHOLD: high_threshold_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        phase_q     <= phase_d;
        bright_q    <= bright_d;
        hold_q      <= hold_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ev_q <= in_data_i;
    end
    if (cmd_i.tgt_load) begin
      target_q <= cmd_i.tgt_from_div ? div_quo[BrightW-1:0] : tgt_direct;
    end
    if (cmd_i.step_load) begin
      step_q <= div_quo[BrightW-1:0];
    end
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ tb/sv/tb_led_fade_voltage_display_sequencer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_fade_voltage_display_sequencer
// self-checking bench for the voltage display fade sequencer: a scripted
// pass over every event kind and the zero-hold path, then random event
// streams under many register settings, each result checked against an
// in-bench model of the wait / fade-in / hold / fade-out sequence
// ----------------------------------------------------------------------------
module tb_led_fade_voltage_display_sequencer;
  import lfvds_pkg::*;

  // block parameters, kept at the defaults and passed down explicitly
  localparam int unsigned RAMP_TOP         = 150;
  localparam int unsigned FADE_IN_DIVISOR  = 5;
  localparam int unsigned WAIT_TICKS       = 16;
  localparam int unsigned TICKS_PER_SECOND = 62;

  // sequencer stages as seen by the model
  localparam int unsigned PH_FADE_IN  = WAIT_TICKS;
  localparam int unsigned PH_HOLD     = WAIT_TICKS + 1;
  localparam int unsigned PH_FADE_OUT = WAIT_TICKS + 2;

  // event codes the package leaves unnamed: all handled as "other"
  localparam logic [ActW-1:0] ACT_OTHER_LO = 3'd5;
  localparam logic [ActW-1:0] ACT_OTHER_HI = 3'd7;

  // run shape
  localparam int unsigned NUM_PHASES      = 14;
  localparam int unsigned ITEMS_PER_PHASE = 102;
  localparam int unsigned PRESSURE_PHASE  = 2;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES   = 48;   // about the worst fade-in tick
  localparam int unsigned WATCHDOG_LIMIT  = 3000;
  localparam int unsigned MAX_REPORTS     = 10;

  // results that can be read straight off the event
  localparam out_t RES_QUIET = '{brightness: 8'd0, frame_drawn: 1'b0,
                                 leds_off: 1'b0, exit_request: 1'b0};
  localparam out_t RES_OFF   = '{brightness: 8'd0, frame_drawn: 1'b0,
                                 leds_off: 1'b1, exit_request: 1'b0};
  localparam out_t RES_EXIT  = '{brightness: 8'd0, frame_drawn: 1'b0,
                                 leds_off: 1'b0, exit_request: 1'b1};

  // event on its way into the block, with an optional hand-typed result
  typedef struct packed {
    in_t  ev;
    logic fixed;
    out_t want;
  } pending_t;

  // one line of the scripted part
  typedef struct {
    logic [ActW-1:0] act;
    logic            other_ch;
    logic            busy;
    int unsigned     reps;
    logic            fixed;
    out_t            want;
  } script_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;

  lfvds_in_if  in_ch ();
  lfvds_out_if out_ch ();

  led_fade_voltage_display_sequencer #(
    .RAMP_TOP         (RAMP_TOP),
    .FADE_IN_DIVISOR  (FADE_IN_DIVISOR),
    .WAIT_TICKS       (WAIT_TICKS),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // model state and register shadow, reset values as in the block
  // ---------------------------------------------------------------------------
  logic [7:0]       seq_phase  = '0;
  logic [7:0]       cur_bright = '0;
  logic [HoldW-1:0] hold_left  = '0;
  logic [CfgW-1:0]  reg_hold   = 8'd4;
  logic [CfgW-1:0]  reg_level  = 8'd0;
  logic [CfgW-1:0]  reg_low    = 8'd0;
  logic [CfgW-1:0]  reg_high   = ThreshOff;

  pending_t events_in_flight [$];   // offered, not yet taken by the block
  out_t     frames_due [$];         // results owed by the block, oldest first

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  logic        idle_en        = 1'b1;   // random gaps on both sides
  logic        hold_off_req   = 1'b0;   // asks the receiver for one long stall

  // computes the result of one event and moves the sequencer on
  function automatic out_t predict_frame(in_t ev);
    out_t        res;
    int unsigned hi, lo, tgt, b, step;
    res = RES_QUIET;
    // target: last level mapped linearly between the thresholds
    hi = (reg_high == ThreshOff) ? 255 : int'(reg_high) + 1;
    lo = (int'(reg_low) < hi) ? int'(reg_low) : hi - 1;
    if (reg_level < lo) tgt = 0;
    else if (reg_level < hi) tgt = (RAMP_TOP * (reg_level - lo) / (hi - lo)) & 8'hFF;
    else tgt = RAMP_TOP;
    b = cur_bright;

    if (ev.action == ACT_ENTER) begin
      seq_phase  = '0;
      cur_bright = '0;
      hold_left  = 16'(reg_hold * TICKS_PER_SECOND);
      return res;
    end
    if (ev.action == ACT_LEAVE) begin
      res.leds_off = 1'b1;
      return res;
    end
    // button, sleep tick, or anything once the sequence has run out
    if (ev.action == ACT_BUTTON || ev.action == ACT_SLEEP || seq_phase > PH_FADE_OUT) begin
      res.exit_request = 1'b1;
      return res;
    end
    if (ev.main_fade_busy || ev.action != ACT_TICK || ev.sensor_on_other_channel)
      return res;

    if (seq_phase < PH_FADE_IN) begin
      seq_phase++;
    end else if (seq_phase == PH_FADE_IN) begin
      if (tgt > b) begin
        step = (tgt - b) / FADE_IN_DIVISOR;
        if (step == 0) step = 1;
        b += step;
      end else begin
        // reached or already above target: brightness stays as is
        seq_phase++;
      end
    end else if (seq_phase == PH_HOLD) begin
      // a zero count ends the hold instead of wrapping round
      if (hold_left != 0) hold_left--;
      if (hold_left == 0) seq_phase++;
    end else begin
      if (b > FadeOutStep) begin
        b -= FadeOutStep;
      end else begin
        b = 0;
        seq_phase++;
      end
    end
    cur_bright      = b[7:0];
    res.brightness  = cur_bright;
    res.frame_drawn = 1'b1;
    return res;
  endfunction

  // mostly clean tick streams, with some noise and the odd restart
  function automatic in_t random_event();
    in_t         ev;
    int unsigned pick;
    logic [1:0]  noise;
    pick  = $urandom_range(0, 99);
    noise = 2'($urandom);
    ev.action                  = ACT_TICK;
    ev.sensor_on_other_channel = 1'b0;
    ev.main_fade_busy          = 1'b0;
    if (seq_phase > PH_FADE_OUT) begin
      // sequence over: a few exit events, then start again
      if (pick < 50) ev.action = 3'($urandom_range(ACT_TICK, ACT_OTHER_HI));
      else ev.action = ACT_ENTER;
      {ev.sensor_on_other_channel, ev.main_fade_busy} = noise;
    end else if (pick < 80) begin
      // clean tick
    end else if (pick < 86) begin
      {ev.sensor_on_other_channel, ev.main_fade_busy} = 2'($urandom_range(1, 3));
    end else begin
      if (pick < 90) ev.action = 3'($urandom_range(ACT_OTHER_LO, ACT_OTHER_HI));
      else if (pick < 93) ev.action = ACT_LEAVE;
      else if (pick < 96) ev.action = pick[0] ? ACT_BUTTON : ACT_SLEEP;
      else if (pick < 97) ev.action = ACT_ENTER;
      {ev.sensor_on_other_channel, ev.main_fade_busy} = noise;
    end
    return ev;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: checks every result transaction, predicts every event transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pending_t acc;
    out_t     got, want, pred;
    if (out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (frames_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result with none pending: bright %0d frame %0b off %0b exit %0b",
                   $realtime, got.brightness, got.frame_drawn, got.leds_off,
                   got.exit_request);
      end else begin
        want = frames_due.pop_front();
        if (got.brightness !== want.brightness || got.frame_drawn !== want.frame_drawn ||
            got.leds_off !== want.leds_off || got.exit_request !== want.exit_request) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch (expected/actual): bright %0d/%0d frame %0b/%0b",
                     $realtime, want.brightness, got.brightness,
                     want.frame_drawn, got.frame_drawn);
            $display("  off %0b/%0b exit %0b/%0b", want.leds_off, got.leds_off,
                     want.exit_request, got.exit_request);
          end
        end
      end
    end
    if (in_ch.valid && in_ch.ready && events_in_flight.size() != 0) begin
      acc  = events_in_flight.pop_front();
      pred = predict_frame(acc.ev);
      frames_due.push_back(acc.fixed ? acc.want : pred);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random stall bursts, one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        // sender keeps offering while this lasts, so the block backs up
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // event side
  // ---------------------------------------------------------------------------
  // offers one event, waits until it is taken, then may drop valid for a random gap
  task automatic send_event(in_t ev, logic fixed, out_t want);
    events_in_flight.push_back('{ev: ev, fixed: fixed, want: want});
    in_ch.valid <= 1'b1;
    in_ch.data  <= ev;
    do @(posedge clk_i); while (!in_ch.ready);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // drains everything owed, then lets the block settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (events_in_flight.size() != 0 || frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_HOLD_SECONDS:   reg_hold  = val;
      CFG_LAST_LEVEL:     reg_level = val;
      CFG_LOW_THRESHOLD:  reg_low   = val;
      CFG_HIGH_THRESHOLD: reg_high  = val;
      default: ;
    endcase
  endtask

  task automatic write_cfg(logic [CfgW-1:0] hold, logic [CfgW-1:0] level,
                           logic [CfgW-1:0] low, logic [CfgW-1:0] high);
    write_reg(CFG_HOLD_SECONDS, hold);
    write_reg(CFG_LAST_LEVEL, level);
    write_reg(CFG_LOW_THRESHOLD, low);
    write_reg(CFG_HIGH_THRESHOLD, high);
    cfg_we_i <= 1'b0;
  endtask

  // scripted part: zero hold and a zero target, so the whole sequence fits
  script_row_t script [13] = '{
    '{ACT_ENTER,    1'b0, 1'b0,  1, 1'b1, RES_QUIET},
    '{ACT_LEAVE,    1'b0, 1'b1,  1, 1'b1, RES_OFF},    // leave wins over busy
    '{ACT_BUTTON,   1'b0, 1'b0,  1, 1'b1, RES_EXIT},
    '{ACT_SLEEP,    1'b1, 1'b0,  1, 1'b1, RES_EXIT},
    '{ACT_OTHER_HI, 1'b1, 1'b1,  1, 1'b1, RES_QUIET},
    '{ACT_TICK,     1'b0, 1'b1,  1, 1'b1, RES_QUIET},  // main fade busy
    '{ACT_TICK,     1'b1, 1'b0,  1, 1'b1, RES_QUIET},  // converter on other channel
    '{ACT_TICK,     1'b0, 1'b0, 16, 1'b0, RES_QUIET},  // wait stage
    '{ACT_TICK,     1'b0, 1'b0,  1, 1'b0, RES_QUIET},  // fade-in, target not above
    '{ACT_TICK,     1'b0, 1'b0,  1, 1'b0, RES_QUIET},  // hold with zero count
    '{ACT_TICK,     1'b0, 1'b0,  1, 1'b0, RES_QUIET},  // fade-out from zero
    '{ACT_TICK,     1'b0, 1'b0,  1, 1'b1, RES_EXIT},   // sequence over
    '{ACT_ENTER,    1'b1, 1'b1,  1, 1'b1, RES_QUIET}
  };

  // fixed settings {hold, level, low, high}, extremes among them
  logic [CfgW-1:0] fixed_cfg [8][4] = '{
    '{8'd0,   8'd150, 8'd0,   8'd255},   // high threshold disabled
    '{8'd1,   8'd150, 8'd0,   8'd149},   // level at upper threshold: full
    '{8'd2,   8'd100, 8'd200, 8'd50},    // low threshold clamped
    '{8'd1,   8'd20,  8'd30,  8'd255},   // level under low threshold
    '{8'd255, 8'd150, 8'd255, 8'd255},   // longest hold, top of both thresholds
    '{8'd0,   8'd0,   8'd0,   8'd0},     // was off: zero target
    '{8'd1,   8'd1,   8'd0,   8'd0},     // narrowest band
    '{8'd0,   8'd75,  8'd50,  8'd100}    // inside the band
  };

  initial begin
    in_t         ev;
    int unsigned useful;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_HOLD_SECONDS;
    cfg_wdata_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_cfg(8'd0, 8'd1, 8'd0, 8'd254);
    foreach (script[i]) begin
      ev.action                  = script[i].act;
      ev.sensor_on_other_channel = script[i].other_ch;
      ev.main_fade_busy          = script[i].busy;
      repeat (script[i].reps) send_event(ev, script[i].fixed, script[i].want);
    end

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      if (p < 8)
        write_cfg(fixed_cfg[p][0], fixed_cfg[p][1], fixed_cfg[p][2], fixed_cfg[p][3]);
      else
        write_cfg(8'($urandom_range(0, 2)), 8'($urandom_range(0, RAMP_TOP)),
                  8'($urandom), 8'($urandom));
      if (p == PRESSURE_PHASE) hold_off_req = 1'b1;
      if (p == NUM_PHASES - 1) idle_en = 1'b0;   // last stretch runs flat out
      ev = '{action: ACT_ENTER, sensor_on_other_channel: 1'b0, main_fade_busy: 1'b0};
      send_event(ev, 1'b0, RES_QUIET);
      useful = 0;
      while (useful < ITEMS_PER_PHASE) begin
        ev = random_event();
        send_event(ev, 1'b0, RES_QUIET);
        // events the block just passes over do not count
        if (!(ev.action > ACT_SLEEP || (ev.action == ACT_TICK &&
              (ev.main_fade_busy || ev.sensor_on_other_channel))))
          useful++;
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ led_fade_voltage_display_sequencer.f @@
hw/rtl/lfvds_pkg.sv
hw/rtl/lfvds_if.sv
hw/rtl/lfvds_div.sv
hw/rtl/lfvds_ctrl.sv
hw/rtl/lfvds_dp.sv
hw/rtl/led_fade_voltage_display_sequencer.sv
tb/sv/tb_led_fade_voltage_display_sequencer.sv
